// ===== rtl/sfs_pkg.sv =====
// Shared types and operation codes for the shift FIFO with search.
package sfs_pkg;

    localparam int FIELD_DW  = 32;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_GET    = 2'd2;
    localparam logic [1:0] FUNC_SEARCH = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [FIELD_DW-1:0] value;
        logic [INDEX_W-1:0]         index;
    } sfs_req_t;

    typedef struct packed {
        logic signed [FIELD_DW-1:0] data;
        logic [INDEX_W-1:0]         hit_index;
        logic                       ok;
        logic [COUNT_W-1:0]         count;
        logic                       full_res;
        logic                       empty_res;
    } sfs_rsp_t;

    typedef struct packed {
        logic push_en;
        logic pop_en;
    } sfs_cell_ctrl_t;

endpackage

// ===== rtl/sfs_cell.sv =====
// One storage cell of the shifting queue: holds an entry, shifts, and compares.
module sfs_cell
    import sfs_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = 5,
    parameter int SW  = 32
)
(
    input  logic           clk,
    input  sfs_cell_ctrl_t ctrl,
    input  logic [CW-1:0]  count,
    input  logic [SW-1:0]  key,
    input  logic [SW-1:0]  right_entry,
    output logic [SW-1:0]  entry,
    output logic           match
);

    logic [SW-1:0] entry_reg;
    logic [SW-1:0] entry_next;
    logic          held;

    // The cell is live when its position lies below the fill count.
    assign held = CW'(POS) < count;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.pop_en && (CW'(POS + 1) < count) && (POS + 1 < (1 << CW)))
        begin
            entry_next = right_entry;
        end
        else if (ctrl.push_en && (CW'(POS) == count))
        begin
            entry_next = key;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = held && (entry_reg == key);

endmodule

// ===== rtl/shift_fifo_with_search.sv =====
// Top level of the shift-register FIFO with indexed read and value search.
// The result of a transaction is registered and appears in the cycle after it is accepted.
// Throughput: one transaction per cycle while the result is taken; every cell shifts and compares in parallel.
// Reset (rst_n, asynchronous, active low) empties the queue, sets capacity to 16
// and drops any pending result; stored entries are not cleared.
module shift_fifo_with_search
    import sfs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  sfs_req_t         req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sfs_rsp_t         rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    // Stored width: only the low bits of the value field are kept.
    localparam int SW   = (DATA_WIDTH < FIELD_DW) ? DATA_WIDTH : FIELD_DW;
    // Fill count must be able to hold DEPTH itself.
    localparam int CW   = $clog2(DEPTH + 1);
    // Widths for comparing the capacity register against DEPTH and the get index against the count.
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int IXW  = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             rsp_valid_reg;
    sfs_rsp_t         rsp_reg;
    sfs_rsp_t         rsp_next;

    logic             accept;
    logic [CW-1:0]    eff_cap;
    logic [CMPW-1:0]  cap_wide;
    logic [SW-1:0]    key;
    logic             push_ok;
    logic             pop_ok;
    logic             get_ok;
    logic             search_ok;
    sfs_cell_ctrl_t   cell_ctrl;

    logic [SW-1:0]    cell_entry [DEPTH];
    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] first_hit;
    logic [SW-1:0]    get_data;
    logic [INDEX_W-1:0] hit_idx;

    // The output register parts the two sides: a new transaction is taken whenever
    // the held result is absent or is leaving in this cycle.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign key       = req.value[SW-1:0];

    // Capacity of zero acts as one; anything above DEPTH acts as DEPTH.
    assign cap_wide = CMPW'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_wide > CMPW'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    // Request decode. A push is refused once the count reaches the capacity, which
    // also covers a capacity lowered below the current count.
    assign push_ok   = (req.func == FUNC_PUSH) && (count_reg < eff_cap);
    assign pop_ok    = (req.func == FUNC_POP) && (count_reg != '0);
    assign get_ok    = (req.func == FUNC_GET) && (IXW'(req.index) < IXW'(count_reg));
    assign search_ok = (req.func == FUNC_SEARCH) && (|match_vec);

    assign cell_ctrl.push_en = accept && push_ok;
    assign cell_ctrl.pop_en  = accept && pop_ok;

    // The row of cells: each one takes its right neighbor's entry on a pop and the
    // key on a push at the fill position. The last cell has no neighbor.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [SW-1:0] right_entry;
        if (g == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[g + 1];
        end

        sfs_cell #(
            .POS (g),
            .CW  (CW),
            .SW  (SW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .count       (count_reg),
            .key         (key),
            .right_entry (right_entry),
            .entry       (cell_entry[g]),
            .match       (match_vec[g])
        );
    end

    // Lowest matching position: isolate the lowest set bit, then encode it.
    assign first_hit = match_vec & (~match_vec + DEPTH'(1));

    always_comb
    begin
        hit_idx  = '0;
        get_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                hit_idx = hit_idx | INDEX_W'(i);
            end
            if (IXW'(req.index) == IXW'(i))
            begin
                get_data = get_data | cell_entry[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result assembly. Data and hit index are zero unless the request succeeded.
    always_comb
    begin
        rsp_next           = '0;
        rsp_next.count     = COUNT_W'(count_next);
        rsp_next.full_res  = count_next >= eff_cap;
        rsp_next.empty_res = count_next == '0;
        unique case (req.func)
            FUNC_PUSH:
            begin
                rsp_next.ok = push_ok;
            end
            FUNC_POP:
            begin
                rsp_next.ok = pop_ok;
                if (pop_ok)
                begin
                    rsp_next.data = FIELD_DW'(cell_entry[0]);
                end
            end
            FUNC_GET:
            begin
                rsp_next.ok = get_ok;
                if (get_ok)
                begin
                    rsp_next.data = FIELD_DW'(get_data);
                end
            end
            FUNC_SEARCH:
            begin
                rsp_next.ok = search_ok;
                if (search_ok)
                begin
                    rsp_next.hit_index = hit_idx;
                end
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The payload register loads only with a new transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/sfs_checker.sv =====
// Port-level checker for the shift FIFO with search, bound to the top level.
module sfs_checker
    import sfs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input sfs_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input sfs_rsp_t rsp
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Every accepted transaction yields a result in the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted transaction produced no result");

    // Empty flag agrees with the count, and an empty queue is never full.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.empty_res == (rsp.count == '0)) && !(rsp.empty_res && rsp.full_res))
        else $error("status flags disagree with count");

    // A failed request returns zero data and zero hit index.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> (rsp.data == '0) && (rsp.hit_index == '0))
        else $error("failed request carried nonzero data");

endmodule

bind shift_fifo_with_search sfs_checker u_sfs_checker (.*);
